// ----- rtl/oist_pkg.sv -----
// Shared types and codes for the ordered integer set table.
`default_nettype none
package oist_pkg;

   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic search;
      logic shift_init;
      logic shift;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search_done;
      logic shift_done;
      logic found;
      logic is_remove;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/oist_if.sv -----
// Request and response channel interfaces.
`default_nettype none
interface oist_req_if import oist_pkg::*; ();
   logic                      valid;
   logic                      ready;
   op_type                    op;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface oist_rsp_if import oist_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic               is_member;
   logic [COUNT_W-1:0] count;
   logic               empty_res;

   modport source (output valid, output status, output is_member, output count,
                   output empty_res, input ready);
   modport sink   (input valid, input status, input is_member, input count,
                   input empty_res, output ready);
endinterface
`default_nettype wire

// ----- rtl/oist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module oist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/oist_datapath.sv -----
// Datapath: request capture, search and compaction pointers, occupancy, result register.
`default_nettype none
module oist_datapath import oist_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cmd_type  cmd,
   output stat_type      stat,
   oist_req_if.sink      req_ch,
   oist_rsp_if.source    rsp_ch
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   op_type                    op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [CNT_W-1:0]          occ_ff, occ_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          ridx_ff, ridx_in;
   logic [CNT_W-1:0]          slot_ff, slot_in;
   logic                      pend_ff, pend_in;
   logic                      found_ff, found_in;

   status_type                status_ff, status_in;
   logic                      member_ff;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      empty_ff, empty_in;
   logic                      rvalid_ff, rvalid_in;

   logic                      ram_we;
   logic [IDX_W-1:0]          ram_waddr;
   logic [VALUE_W-1:0]        ram_wdata;
   logic [IDX_W-1:0]          ram_raddr;
   logic [VALUE_W-1:0]        ram_rdata;
   logic                      rd_issue;
   logic                      hit;
   logic [CNT_W-1:0]          ridx_dec;
   logic [CNT_W+COUNT_W-1:0]  occ_ext;

   oist_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY),
      .ADDR_W(IDX_W)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign ram_raddr = idx_ff[IDX_W-1:0];
   assign ridx_dec  = ridx_ff - 1'b1;
   assign rd_issue  = (idx_ff < occ_ff) && !(cmd.search && found_ff);
   assign hit       = cmd.search && pend_ff && !found_ff && (ram_rdata == value_ff);

   assign stat.search_done = found_ff || ((idx_ff >= occ_ff) && !pend_ff);
   assign stat.shift_done  = (idx_ff >= occ_ff) && !pend_ff;
   assign stat.found       = found_ff;
   assign stat.is_remove   = (op_ff == OP_REMOVE);
   assign stat.out_free    = !rvalid_ff || rsp_ch.ready;

   // Write port: compaction moves one item down per cycle; an add lands at the tail.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = ridx_dec[IDX_W-1:0];
      ram_wdata = ram_rdata;
      if (cmd.shift && pend_ff) begin
         ram_we = 1'b1;
      end else if (cmd.finish && op_ff == OP_ADD && !found_ff &&
                   occ_ff < CNT_W'(CAPACITY)) begin
         ram_we    = 1'b1;
         ram_waddr = occ_ff[IDX_W-1:0];
         ram_wdata = value_ff;
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      ridx_in  = ridx_ff;
      pend_in  = pend_ff;
      found_in = found_ff;
      slot_in  = slot_ff;
      if (cmd.load) begin
         idx_in   = '0;
         pend_in  = 1'b0;
         found_in = 1'b0;
      end else if (cmd.shift_init) begin
         idx_in  = slot_ff + 1'b1;
         pend_in = 1'b0;
      end else if (cmd.search || cmd.shift) begin
         pend_in = rd_issue;
         if (rd_issue) begin
            idx_in  = idx_ff + 1'b1;
            ridx_in = idx_ff;
         end
         if (hit) begin
            found_in = 1'b1;
            slot_in  = ridx_ff;
         end
      end
   end

   always_comb begin
      occ_in    = occ_ff;
      status_in = ST_DONE;
      unique case (op_ff)
         OP_ADD: begin
            if (found_ff) begin
               status_in = ST_MISS;
            end else if (occ_ff >= CNT_W'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               occ_in = occ_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!found_ff) begin
               status_in = ST_MISS;
            end else begin
               occ_in = occ_ff - 1'b1;
            end
         end
         OP_QUERY: status_in = found_ff ? ST_DONE : ST_MISS;
         OP_CLEAR: occ_in = '0;
         default:  occ_in = occ_ff;
      endcase
      occ_ext  = {{COUNT_W{1'b0}}, occ_in};
      count_in = occ_ext[COUNT_W-1:0];
      empty_in = (occ_in == '0);

      rvalid_in = rvalid_ff;
      if (cmd.finish) begin
         rvalid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         rvalid_ff <= 1'b0;
         pend_ff   <= 1'b0;
         found_ff  <= 1'b0;
         idx_ff    <= '0;
      end else begin
         rvalid_ff <= rvalid_in;
         pend_ff   <= pend_in;
         found_ff  <= found_in;
         idx_ff    <= idx_in;
         if (cmd.finish) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      ridx_ff <= ridx_in;
      slot_ff <= slot_in;
      if (cmd.load) begin
         op_ff    <= req_ch.op;
         value_ff <= req_ch.value;
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         member_ff <= found_ff;
         count_ff  <= count_in;
         empty_ff  <= empty_in;
      end
   end

   assign rsp_ch.valid     = rvalid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.is_member = member_ff;
   assign rsp_ch.count     = count_ff;
   assign rsp_ch.empty_res = empty_ff;

endmodule
`default_nettype wire

// ----- rtl/oist_ctrl.sv -----
// Controller: sequences search, compaction and result write-back for each item.
`default_nettype none
module oist_ctrl import oist_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_SHIFT,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   always_comb begin
      cmd            = '0;
      cmd.load       = accept;
      cmd.search     = (state_ff == S_SEARCH);
      cmd.shift_init = (state_ff == S_SEARCH) && stat.search_done &&
                       stat.is_remove && stat.found;
      cmd.shift      = (state_ff == S_SHIFT);
      cmd.finish     = (state_ff == S_FINISH) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_SEARCH;
                  ready_ff <= 1'b0;
               end
            end
            S_SEARCH: begin
               if (stat.search_done) begin
                  state_ff <= (stat.is_remove && stat.found) ? S_SHIFT : S_FINISH;
               end
            end
            S_SHIFT: begin
               if (stat.shift_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- rtl/ordered_int_set_table_top.sv -----
// Ordered integer set table: insertion-ordered set of distinct 32-bit values in one RAM.
// Steps: the request is accepted, then the search reads the n occupied entries (one RAM read
// per cycle) and ends early on a hit; a remove then compacts the later entries down one slot,
// and the result is then written to the output register.
// A new item is accepted only after the previous item has written its result.
// A result waits in its output register while the next item is accepted.
// Reset (synchronous): empties the set; no RAM clearing pass, only occupied entries are read.
`default_nettype none
module ordered_int_set_table_top import oist_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input wire logic   clock,
   input wire logic   reset,
   oist_req_if.sink   req_ch,
   oist_rsp_if.source rsp_ch
);

   cmd_type  cmd;
   stat_type stat;

   oist_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   oist_datapath #(
      .CAPACITY(CAPACITY)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the ordered integer set table: directed table, then random traffic.
`default_nettype none
module tb import oist_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAPACITY = 16;
   localparam int POOL_SIZE    = 24;
   localparam int ITEMS_PER_PHASE = 335;

   typedef struct packed {
      status_type         status;
      logic               is_member;
      logic [COUNT_W-1:0] count;
      logic               empty_res;
   } set_rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] value;
      logic        typed;
      set_rsp_type rsp;
   } dir_row_type;

   // Rows with typed = 1 carry the response as it must be; the rest use the predictor.
   localparam dir_row_type DIR_TABLE [26] = '{
      '{OP_QUERY,  32'h0000_0000, 1'b1, '{ST_MISS, 1'b0, 5'd0, 1'b1}},
      '{OP_REMOVE, 32'h0000_0005, 1'b1, '{ST_MISS, 1'b0, 5'd0, 1'b1}},
      '{OP_ADD,    32'h8000_0000, 1'b1, '{ST_DONE, 1'b0, 5'd1, 1'b0}},
      '{OP_ADD,    32'h7FFF_FFFF, 1'b1, '{ST_DONE, 1'b0, 5'd2, 1'b0}},
      '{OP_ADD,    32'h8000_0000, 1'b1, '{ST_MISS, 1'b1, 5'd2, 1'b0}},
      '{OP_ADD,    32'h0000_0000, 1'b1, '{ST_DONE, 1'b0, 5'd3, 1'b0}},
      '{OP_ADD,    32'hFFFF_FFFF, 1'b1, '{ST_DONE, 1'b0, 5'd4, 1'b0}},
      '{OP_QUERY,  32'h7FFF_FFFF, 1'b1, '{ST_DONE, 1'b1, 5'd4, 1'b0}},
      '{OP_QUERY,  32'h7FFF_FFFE, 1'b1, '{ST_MISS, 1'b0, 5'd4, 1'b0}},
      '{OP_ADD,    32'h0000_0001, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0002, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0003, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0004, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0005, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0006, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0007, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0008, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_0009, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_000A, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_000B, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      '{OP_ADD,    32'h0000_000C, 1'b0, '{ST_DONE, 1'b0, 5'd0, 1'b0}},
      // table is full now
      '{OP_ADD,    32'h1234_5678, 1'b1, '{ST_FULL, 1'b0, 5'd16, 1'b0}},
      '{OP_REMOVE, 32'h8000_0000, 1'b1, '{ST_DONE, 1'b1, 5'd15, 1'b0}},
      '{OP_REMOVE, 32'h0000_000C, 1'b1, '{ST_DONE, 1'b1, 5'd14, 1'b0}},
      '{OP_CLEAR,  32'h0000_0000, 1'b1, '{ST_DONE, 1'b1, 5'd0, 1'b1}},
      '{OP_CLEAR,  32'h0000_0005, 1'b1, '{ST_DONE, 1'b0, 5'd0, 1'b1}}
   };

   logic clock;
   logic reset;

   oist_req_if req_ch ();
   oist_rsp_if rsp_ch ();

   ordered_int_set_table_top #(.CAPACITY(SET_CAPACITY)) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predictor state
   logic [31:0] set_vals [SET_CAPACITY];
   int          set_n;

   set_rsp_type expected_rsps [$];
   logic [31:0] value_pool [POOL_SIZE];
   int          send_idle_pct;
   int          recv_stall_pct;
   int          errors;
   int          op_hits [4];
   int          full_rejects;
   int          member_hits;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic set_rsp_type apply_request(op_type op, logic [31:0] v);
      int          slot;
      set_rsp_type r;
      slot = -1;
      for (int i = 0; i < set_n; i++) begin
         if (slot < 0 && set_vals[i] == v) slot = i;
      end
      r.status    = ST_DONE;
      r.is_member = (slot >= 0);
      case (op)
         OP_ADD: begin
            if (slot >= 0) r.status = ST_MISS;
            else if (set_n >= SET_CAPACITY) r.status = ST_FULL;
            else begin
               set_vals[set_n] = v;
               set_n++;
            end
         end
         OP_REMOVE: begin
            if (slot < 0) r.status = ST_MISS;
            else begin
               // close the gap, keep insertion order
               for (int i = slot; i < set_n - 1; i++) set_vals[i] = set_vals[i + 1];
               set_n--;
            end
         end
         OP_QUERY: begin
            if (slot < 0) r.status = ST_MISS;
         end
         default: set_n = 0;
      endcase
      r.count     = set_n[COUNT_W-1:0];
      r.empty_res = (set_n == 0);
      return r;
   endfunction

   task automatic send_request(op_type op, logic [31:0] v, logic typed, set_rsp_type typed_rsp);
      set_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= v;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = apply_request(op, v);
      expected_rsps.push_back(typed ? typed_rsp : predicted);
      op_hits[op]++;
      if (predicted.status == ST_FULL) full_rejects++;
      if (predicted.is_member) member_hits++;
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      if ($urandom_range(3) == 0) return $urandom;
      return value_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : rsp_check
      set_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response status=%0d member=%0b count=%0d empty=%0b",
                     $realtime, rsp_ch.status, rsp_ch.is_member, rsp_ch.count,
                     rsp_ch.empty_res);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $realtime, want.status,
                        rsp_ch.status);
               errors++;
            end
            if (rsp_ch.is_member !== want.is_member) begin
               $display("%0t: is_member expected %0b got %0b", $realtime, want.is_member,
                        rsp_ch.is_member);
               errors++;
            end
            if (rsp_ch.count !== want.count) begin
               $display("%0t: count expected %0d got %0d", $realtime, want.count,
                        rsp_ch.count);
               errors++;
            end
            if (rsp_ch.empty_res !== want.empty_res) begin
               $display("%0t: empty_res expected %0b got %0b", $realtime, want.empty_res,
                        rsp_ch.empty_res);
               errors++;
            end
         end
      end
   end

   initial begin
      int          sel;
      int          add_pct;
      op_type      op;
      logic [31:0] v;
      int          send_idle_tab [4];
      int          recv_stall_tab [4];
      int          add_tab [4];

      send_idle_tab  = '{0, 54, 0, 26};
      recv_stall_tab = '{0, 0, 54, 26};
      add_tab        = '{50, 40, 55, 45};
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_ADD;
      req_ch.value   = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      errors         = 0;
      full_rejects   = 0;
      member_hits    = 0;
      op_hits        = '{0, 0, 0, 0};
      set_n          = 0;

      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i])
         send_request(DIR_TABLE[i].op, DIR_TABLE[i].value, DIR_TABLE[i].typed, DIR_TABLE[i].rsp);
      drain_responses();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_idle_tab[ph];
         recv_stall_pct = recv_stall_tab[ph];
         add_pct        = add_tab[ph];
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (ph == 1 && k == ITEMS_PER_PHASE / 2) drain_responses();
            sel = $urandom_range(99);
            if (sel < add_pct) op = OP_ADD;
            else if (sel < add_pct + 20) op = OP_REMOVE;
            else if (sel < 97) op = OP_QUERY;
            else op = OP_CLEAR;
            // removes and queries mostly target values that are held
            if ((op == OP_REMOVE || op == OP_QUERY) && set_n > 0 && $urandom_range(1) == 1)
               v = set_vals[$urandom_range(set_n - 1)];
            else
               v = pick_value();
            send_request(op, v, 1'b0, '0);
         end
         drain_responses();
      end

      repeat (40) @(posedge clock);
      $display("Covered %0d items: %0d add, %0d remove, %0d query, %0d clear.",
               op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
               op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
      $display("Full-table rejects %0d, requests hitting a held value %0d.",
               full_rejects, member_hits);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/oist_pkg.sv
rtl/oist_if.sv
rtl/oist_ram.sv
rtl/oist_datapath.sv
rtl/oist_ctrl.sv
rtl/ordered_int_set_table_top.sv
tb/tb.sv
